### hdl/kss_pkg.sv
// Shared types, constants and helpers for the knot span search unit.
package kss_pkg;

    localparam int MAX_KNOTS = 256;
    localparam int KNOT_AW   = $clog2(MAX_KNOTS);

    localparam int KNOT_W    = 32;
    localparam int ORDER_W   = 5;
    localparam int COUNT_W   = 9;
    localparam int TOL_W     = 16;
    localparam int SPAN_W    = 8;
    localparam int KIDX_W    = 8;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [ORDER_W-1:0] ORDER_RST = 5'd4;
    localparam logic [COUNT_W-1:0] COUNT_RST = 9'd8;
    localparam logic [TOL_W-1:0]   TOL_RST   = 16'd1;

    // Register index codes, taken from paddr[3:2]
    localparam logic [1:0] REG_ORDER = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [COUNT_W-1:0] knot_count;
        logic [TOL_W-1:0]   tolerance;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LAST = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // Knots in use, limited to the store depth
    function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] kc);
        logic [31:0] w;
        logic [31:0] m;
        w = 32'(kc);
        m = 32'(MAX_KNOTS);
        if (w > m) begin
            return COUNT_W'(m);
        end
        return kc;
    endfunction

    function automatic logic [KNOT_AW-1:0] to_addr(input logic [COUNT_W-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[KNOT_AW-1:0];
    endfunction

endpackage

### hdl/kss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/kss_cfg.sv
// APB configuration registers: order, knot count and tolerance.
module kss_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kss_pkg::APB_AW-1:0]   paddr,
    input  logic [kss_pkg::APB_DW-1:0]   pwdata,
    output logic [kss_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output kss_pkg::t_cfg                o_cfg
);

    kss_pkg::t_cfg r_cfg;
    kss_pkg::t_cfg n_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                kss_pkg::REG_ORDER: n_cfg.order      = pwdata[kss_pkg::ORDER_W-1:0];
                kss_pkg::REG_COUNT: n_cfg.knot_count = pwdata[kss_pkg::COUNT_W-1:0];
                kss_pkg::REG_TOL:   n_cfg.tolerance  = pwdata[kss_pkg::TOL_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.order      <= kss_pkg::ORDER_RST;
            r_cfg.knot_count <= kss_pkg::COUNT_RST;
            r_cfg.tolerance  <= kss_pkg::TOL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            kss_pkg::REG_ORDER: prdata = kss_pkg::APB_DW'(r_cfg.order);
            kss_pkg::REG_COUNT: prdata = kss_pkg::APB_DW'(r_cfg.knot_count);
            kss_pkg::REG_TOL:   prdata = kss_pkg::APB_DW'(r_cfg.tolerance);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/kss_ctrl.sv
// Search sequencer: knot writes, last-knot test, linear scan and result register.
module kss_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kss_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [kss_pkg::KIDX_W-1:0]    i_knot_index,
    input  logic [kss_pkg::KNOT_W-1:0]    i_knot_value,
    input  logic [kss_pkg::KNOT_W-1:0]    i_param_t,
    output logic                          o_we,
    output logic [kss_pkg::KNOT_AW-1:0]   o_waddr,
    output logic [kss_pkg::KNOT_W-1:0]    o_wdata,
    output logic [kss_pkg::KNOT_AW-1:0]   o_raddr,
    input  logic [kss_pkg::KNOT_W-1:0]    i_rdata,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [kss_pkg::SPAN_W-1:0]    o_span_index,
    output logic                          o_span_valid
);

    kss_pkg::t_state                r_state, n_state;
    logic [kss_pkg::KNOT_W-1:0]     r_t, n_t;
    logic [kss_pkg::COUNT_W-1:0]    r_i, n_i;
    logic [kss_pkg::COUNT_W-1:0]    r_last, n_last;
    logic [kss_pkg::SPAN_W-1:0]     r_span, n_span;
    logic                           r_ok, n_ok;
    logic                           r_ov, n_ov;
    logic [kss_pkg::SPAN_W-1:0]     r_oi, n_oi;
    logic                           r_ook, n_ook;

    logic                           accept;
    logic [kss_pkg::COUNT_W-1:0]    cnt;
    logic [kss_pkg::COUNT_W-1:0]    ord;
    logic                           bad_cfg;
    logic [kss_pkg::COUNT_W-1:0]    rd_idx;
    logic signed [kss_pkg::KNOT_W:0] diff;
    logic [kss_pkg::KNOT_W:0]       mag;
    logic                           near;
    logic                           below;
    logic                           slot_free;

    assign o_ready = (r_state == kss_pkg::ST_IDLE);
    assign accept  = i_valid & o_ready;

    assign cnt     = kss_pkg::sat_count(i_cfg.knot_count);
    assign ord     = kss_pkg::COUNT_W'(i_cfg.order);
    assign bad_cfg = (ord == '0) || (cnt == '0) || (ord > cnt);

    // Knot writes go straight to the store; the index is always in range at depth 256
    assign o_we    = accept && (i_kind == kss_pkg::KIND_WRITE)
                     && (32'(i_knot_index) < 32'(kss_pkg::MAX_KNOTS));
    assign o_waddr = kss_pkg::to_addr(kss_pkg::COUNT_W'(i_knot_index));
    assign o_wdata = i_knot_value;

    always_comb begin
        case (r_state)
            kss_pkg::ST_IDLE: rd_idx = cnt - 1'b1;
            kss_pkg::ST_LAST: rd_idx = ord - 1'b1;
            kss_pkg::ST_SCAN: rd_idx = r_i + 1'b1;
            default:          rd_idx = '0;
        endcase
    end
    assign o_raddr = kss_pkg::to_addr(rd_idx);

    // |t - knot| over 33 bits, then compare against tolerance
    assign diff  = $signed({r_t[kss_pkg::KNOT_W-1], r_t})
                 - $signed({i_rdata[kss_pkg::KNOT_W-1], i_rdata});
    assign mag   = diff[kss_pkg::KNOT_W] ? 33'(-diff) : 33'(diff);
    assign near  = mag <= 33'(i_cfg.tolerance);
    assign below = $signed(r_t) < $signed(i_rdata);

    assign slot_free = !r_ov || i_res_ready;

    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        n_i     = r_i;
        n_last  = r_last;
        n_span  = r_span;
        n_ok    = r_ok;
        n_ov    = r_ov;
        n_oi    = r_oi;
        n_ook   = r_ook;
        if (r_ov && i_res_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            kss_pkg::ST_IDLE: begin
                if (accept && (i_kind == kss_pkg::KIND_QUERY)) begin
                    n_t = i_param_t;
                    if (bad_cfg) begin
                        n_ok    = 1'b0;
                        n_span  = '0;
                        n_state = kss_pkg::ST_DONE;
                    end else begin
                        n_last  = cnt - ord;
                        n_state = kss_pkg::ST_LAST;
                    end
                end
            end
            kss_pkg::ST_LAST: begin
                if (near) begin
                    n_ok    = (r_last != '0);
                    n_span  = (r_last != '0) ? kss_pkg::SPAN_W'(r_last - 1'b1) : '0;
                    n_state = kss_pkg::ST_DONE;
                end else if ((ord - 1'b1) > r_last) begin
                    // Empty scan window: no knot lies in order-1..last
                    n_ok    = 1'b0;
                    n_span  = '0;
                    n_state = kss_pkg::ST_DONE;
                end else begin
                    n_i     = ord - 1'b1;
                    n_state = kss_pkg::ST_SCAN;
                end
            end
            kss_pkg::ST_SCAN: begin
                if (below) begin
                    n_ok    = (r_i != '0);
                    n_span  = (r_i != '0) ? kss_pkg::SPAN_W'(r_i - 1'b1) : '0;
                    n_state = kss_pkg::ST_DONE;
                end else if (r_i == r_last) begin
                    n_ok    = 1'b0;
                    n_span  = '0;
                    n_state = kss_pkg::ST_DONE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            kss_pkg::ST_DONE: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_oi    = r_span;
                    n_ook   = r_ok;
                    n_state = kss_pkg::ST_IDLE;
                end
            end
            default: n_state = kss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kss_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_t    <= n_t;
        r_i    <= n_i;
        r_last <= n_last;
        r_span <= n_span;
        r_ok   <= n_ok;
        r_oi   <= n_oi;
        r_ook  <= n_ook;
    end

    assign o_res_valid  = r_ov;
    assign o_span_index = r_oi;
    assign o_span_valid = r_ook;

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kss_pkg::ST_SCAN) |-> (r_i <= r_last))
        else $error("scan index ran past last knot in use");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == kss_pkg::KIND_QUERY)) |=> (r_state != kss_pkg::ST_IDLE))
        else $error("query accepted without leaving idle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ook) |-> (r_oi == '0))
        else $error("failed search carries nonzero span");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_res_ready) |=> (r_ov && $stable(r_oi) && $stable(r_ook)))
        else $error("pending result overwritten");
`endif

endmodule

### hdl/knot_span_search_unit.sv
// Top level of the knot span search unit: stream ports, APB registers, knot store.
//
//  Channel   Dir  Handshake            Carries
//  s stream  in   i_s_tvalid/o_s_tready  knot write or span query
//  m stream  out  o_m_tvalid/i_m_tready  span result, one per query
//  APB       in   psel/penable/pready    order, knot_count, tolerance
//
// A knot write does not leave idle, so the unit stays ready for the next item.
// A query passes through a store read of the last knot, then k scan steps,
// k being the knots scanned (at most knot_count - 2*order + 2), at one
// knot per cycle on the store read port, then a step that hands the result
// to the output register. Queries whose order/count combination is invalid
// skip the reads and go straight to that final step.
// Reset is synchronous and active low; the knot store is not cleared.
// A result waiting on i_m_tready does not block new input; the next query
// holds in its final step until the output register drains.
module knot_span_search_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Slave stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [71:0]                 i_s_tdata,  // knot_index[7:0], knot_value[39:8], param_t[71:40]
    input  logic                        i_s_tuser,  // kind
    // Master stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata,  // span_index[7:0]
    output logic                        o_m_tuser,  // span_valid
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kss_pkg::APB_AW-1:0]  paddr,
    input  logic [kss_pkg::APB_DW-1:0]  pwdata,
    output logic [kss_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    kss_pkg::t_cfg                  cfg;
    logic                           st_we;
    logic [kss_pkg::KNOT_AW-1:0]    st_waddr;
    logic [kss_pkg::KNOT_W-1:0]     st_wdata;
    logic [kss_pkg::KNOT_AW-1:0]    st_raddr;
    logic [kss_pkg::KNOT_W-1:0]     st_rdata;

    kss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Knot store: one write port for knot loads, one read port for the search
    kss_ram #(
        .WIDTH (kss_pkg::KNOT_W),
        .DEPTH (kss_pkg::MAX_KNOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Unpack the input transfer and drive the sequencer
    kss_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_kind       (i_s_tuser),
        .i_knot_index (i_s_tdata[7:0]),
        .i_knot_value (i_s_tdata[39:8]),
        .i_param_t    (i_s_tdata[71:40]),
        .o_we         (st_we),
        .o_waddr      (st_waddr),
        .o_wdata      (st_wdata),
        .o_raddr      (st_raddr),
        .i_rdata      (st_rdata),
        .o_res_valid  (o_m_tvalid),
        .i_res_ready  (i_m_tready),
        .o_span_index (o_m_tdata),
        .o_span_valid (o_m_tuser)
    );

endmodule

### verif/knot_span_search_unit_tb.sv
// Self-checking testbench for the knot span search unit: directed and random stream traffic.
module knot_span_search_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Q16.16 one, and the extremes of a signed knot or parameter
    localparam longint             Q_ONE       = 65536;
    localparam logic signed [31:0] Q_MIN       = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX       = 32'sh7fff_ffff;
    // Cycles with no transfer on any port before the run is declared hung
    localparam int                 HANG_LIMIT  = 5000;
    // Cycles to let a trailing knot write settle before touching registers
    localparam int                 SETTLE_CYC  = 8;
    localparam int                 RANDOM_ITEMS = 220;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    // One predicted span result, with the parameter that produced it
    typedef struct {
        logic signed [31:0]         param;
        logic [kss_pkg::SPAN_W-1:0] span;
        logic                       found;
    } t_span_rec;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_s_tvalid = 1'b0;
    logic                        o_s_tready;
    logic [71:0]                 i_s_tdata  = '0;  // knot_index[7:0], knot_value[39:8], param_t[71:40]
    logic                        i_s_tuser  = 1'b0;  // kind
    logic                        o_m_tvalid;
    logic                        i_m_tready = 1'b0;
    logic [7:0]                  o_m_tdata;  // span_index[7:0]
    logic                        o_m_tuser;  // span_valid
    logic                        psel       = 1'b0;
    logic                        penable    = 1'b0;
    logic                        pwrite     = 1'b0;
    logic [kss_pkg::APB_AW-1:0]  paddr      = '0;
    logic [kss_pkg::APB_DW-1:0]  pwdata     = '0;
    logic [kss_pkg::APB_DW-1:0]  prdata;
    logic                        pready;

    // Shadow of the block: knot store and the three registers
    logic signed [31:0]  knot_shadow [kss_pkg::MAX_KNOTS];
    int                  cfg_order = int'(kss_pkg::ORDER_RST);
    int                  cfg_count = int'(kss_pkg::COUNT_RST);
    int                  cfg_tol   = int'(kss_pkg::TOL_RST);

    t_span_rec           pending_spans[$];
    int                  err_count   = 0;
    int                  burst_left  = 0;
    int                  rand_items  = 0;
    int                  idle_cycles = 0;
    t_rx_mode            rx_mode     = RX_OPEN;
    int                  rx_left     = 0;

    knot_span_search_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Span predictor
    // ------------------------------------------------------------------

    // Locate the span of t in the shadow knot vector under the shadow registers.
    // Near the last knot in use the answer is last-1; otherwise take the first
    // knot in order-1..last strictly above t and step one back.
    function automatic void locate_span(input logic signed [31:0] t,
                                        output logic [kss_pkg::SPAN_W-1:0] span,
                                        output logic found);
        int     n;
        int     last;
        longint dev;
        span  = '0;
        found = 1'b0;
        n = (cfg_count > kss_pkg::MAX_KNOTS) ? kss_pkg::MAX_KNOTS : cfg_count;
        if (cfg_order == 0 || n == 0 || cfg_order > n) begin
            return;
        end
        last = n - cfg_order;
        dev = longint'(t) - longint'(knot_shadow[n-1]);
        if (dev < 0) begin
            dev = -dev;
        end
        if (dev <= longint'(cfg_tol)) begin
            // Last-1 would go negative when the vector holds a single span
            if (last == 0) begin
                return;
            end
            span  = kss_pkg::SPAN_W'(last - 1);
            found = 1'b1;
            return;
        end
        for (int i = cfg_order - 1; i <= last; i++) begin
            if (t < knot_shadow[i]) begin
                // A span below knot zero does not exist
                if (i == 0) begin
                    return;
                end
                span  = kss_pkg::SPAN_W'(i - 1);
                found = 1'b1;
                return;
            end
        end
    endfunction

    function automatic logic signed [31:0] clamp_q(input longint v);
        if (v > longint'(Q_MAX)) begin
            return Q_MAX;
        end
        if (v < longint'(Q_MIN)) begin
            return Q_MIN;
        end
        return 32'(v);
    endfunction

    // Pick a parameter close to a stored knot, often around the last knot in use
    // so that the tolerance window and its edges get hit.
    function automatic logic signed [31:0] param_near_knot(input int n_used);
        int     j;
        longint delta;
        j = $urandom_range(0, n_used - 1);
        if ($urandom_range(0, 3) == 0) begin
            j = n_used - 1;
        end
        case ($urandom_range(0, 7))
            0: delta = 0;
            1: delta = 1;
            2: delta = -1;
            3: delta = longint'(cfg_tol);
            4: delta = -longint'(cfg_tol) - 1;
            5: delta = longint'(cfg_tol) + 1;
            default: delta = longint'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
        endcase
        return clamp_q(longint'(knot_shadow[j]) + delta);
    endfunction

    function automatic logic [kss_pkg::APB_DW-1:0] reg_value(input logic [1:0] reg_idx);
        case (reg_idx)
            kss_pkg::REG_ORDER: return kss_pkg::APB_DW'(cfg_order);
            kss_pkg::REG_COUNT: return kss_pkg::APB_DW'(cfg_count);
            kss_pkg::REG_TOL:   return kss_pkg::APB_DW'(cfg_tol);
            default:            return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $realtime, msg);
        err_count++;
    endtask

    // Compare every span transfer with the oldest prediction.
    always @(posedge i_clk) begin : check_spans
        t_span_rec want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_spans.size() == 0) begin
                report_mismatch($sformatf("unexpected span result index=%0d valid=%0b",
                                          o_m_tdata, o_m_tuser));
            end else begin
                want = pending_spans.pop_front();
                if (o_m_tdata !== want.span) begin
                    report_mismatch($sformatf("t=%0d span_index got %0d want %0d",
                                              want.param, o_m_tdata, want.span));
                end
                if (o_m_tuser !== want.found) begin
                    report_mismatch($sformatf("t=%0d span_valid got %0b want %0b",
                                              want.param, o_m_tuser, want.found));
                end
            end
        end
    end

    // Hang detector: count cycles in which no port moves a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver back-pressure: switch among open, coin-flip, sparse and periodic
    // patterns at random intervals so stalls land on every phase of a search.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_COIN:   i_m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: i_m_tready <= ($urandom_range(0, 4) == 0);
            default:   i_m_tready <= ((rx_left % 16) < 11);
        endcase
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one item on the slave stream. Items go out in bursts of random
    // length; between bursts tvalid may drop for a random gap. Within a burst
    // tvalid stays high and only the payload changes.
    task automatic send_item(input logic kind, input logic [kss_pkg::KIDX_W-1:0] idx,
                             input logic signed [31:0] kval,
                             input logic signed [31:0] t);
        int        gap;
        t_span_rec rec;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {t, kval, idx};
        do @(posedge i_clk); while (!o_s_tready);
        // Transfer taken at this edge: advance the shadow
        if (kind == kss_pkg::KIND_WRITE) begin
            knot_shadow[idx] = kval;
        end else begin
            rec.param = t;
            locate_span(t, rec.span, rec.found);
            pending_spans.push_back(rec);
        end
    endtask

    // Query with random filler in the fields a query does not use
    task automatic send_query(input logic signed [31:0] t);
        send_item(kss_pkg::KIND_QUERY, kss_pkg::KIDX_W'($urandom), 32'($urandom), t);
    endtask

    // Knot write with random filler in the parameter field
    task automatic send_knot(input int idx, input logic signed [31:0] v);
        send_item(kss_pkg::KIND_WRITE, kss_pkg::KIDX_W'(idx), v, 32'($urandom));
    endtask

    // Hold the sender until every predicted span has come back, then give a
    // trailing knot write time to land.
    task automatic wait_for_spans();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_spans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, access cycle, done when pready is seen.
    task automatic apb_access(input logic wr, input logic [1:0] reg_idx,
                              input logic [kss_pkg::APB_DW-1:0] wdata,
                              output logic [kss_pkg::APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic [1:0] reg_idx);
        logic [kss_pkg::APB_DW-1:0] got;
        apb_access(1'b0, reg_idx, '0, got);
        if (got !== reg_value(reg_idx)) begin
            report_mismatch($sformatf("register %0d reads %0h want %0h",
                                      reg_idx, got, reg_value(reg_idx)));
        end
    endtask

    // Write a register (block must be idle), mirror it masked to its width,
    // then read it back.
    task automatic write_register(input logic [1:0] reg_idx,
                                  input logic [kss_pkg::APB_DW-1:0] value);
        logic [kss_pkg::APB_DW-1:0] unused;
        apb_access(1'b1, reg_idx, value, unused);
        case (reg_idx)
            kss_pkg::REG_ORDER: cfg_order = int'(value[kss_pkg::ORDER_W-1:0]);
            kss_pkg::REG_COUNT: cfg_count = int'(value[kss_pkg::COUNT_W-1:0]);
            default:            cfg_tol   = int'(value[kss_pkg::TOL_W-1:0]);
        endcase
        check_register(reg_idx);
    endtask

    task automatic set_config(input int order, input int count, input int tol);
        write_register(kss_pkg::REG_ORDER,
                       {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, 5'(order)});
        write_register(kss_pkg::REG_COUNT,
                       {$urandom_range(0, 1) ? 23'($urandom) : 23'd0, 9'(count)});
        write_register(kss_pkg::REG_TOL,
                       {$urandom_range(0, 1) ? 16'($urandom) : 16'd0, 16'(tol)});
    endtask

    // Load a nondecreasing knot vector into positions 0..n-1, repeating knots
    // now and then as a clamped vector does.
    task automatic load_knot_vector(input int n);
        longint v;
        v = -longint'($urandom_range(0, 1 << 24));
        for (int i = 0; i < n; i++) begin
            send_knot(i, clamp_q(v));
            if ($urandom_range(0, 3) != 0) begin
                v += $urandom_range(1, 2 * Q_ONE);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill the whole store so no later query reads an unwritten position.
    task automatic fill_knot_store();
        load_knot_vector(kss_pkg::MAX_KNOTS);
    endtask

    // Reset register values, then queries across the default eight-knot, order-4 setup:
    // field extremes, exact knot hits and both edges of the last-knot tolerance.
    task automatic test_reset_config();
        check_register(kss_pkg::REG_ORDER);
        check_register(kss_pkg::REG_COUNT);
        check_register(kss_pkg::REG_TOL);
        send_query(Q_MIN);
        send_query(knot_shadow[3]);
        send_query(clamp_q(longint'(knot_shadow[4]) - 1));
        send_query(knot_shadow[6]);
        send_query(clamp_q(longint'(knot_shadow[7]) - 1));
        send_query(knot_shadow[7]);
        send_query(clamp_q(longint'(knot_shadow[7]) + 1));
        send_query(clamp_q(longint'(knot_shadow[7]) + 2));
        send_query(Q_MAX);
    endtask

    // Settings under which the search must fail or saturate.
    task automatic test_degenerate_config();
        wait_for_spans();
        // Order zero
        set_config(0, 8, 1);
        send_query(knot_shadow[2]);
        wait_for_spans();
        // Knot count zero
        set_config(4, 0, 1);
        send_query(knot_shadow[2]);
        wait_for_spans();
        // Order above knot count
        set_config(4, 3, 1);
        send_query(knot_shadow[1]);
        wait_for_spans();
        // Order equal to count: one span only, last-1 goes negative
        set_config(4, 4, 1);
        send_query(knot_shadow[3]);
        wait_for_spans();
        // Count above the store depth saturates; below knot zero has no span
        set_config(1, 300, 0);
        send_query(Q_MIN);
        send_query(knot_shadow[128]);
    endtask

    // Extreme knot values with extreme register values.
    task automatic test_extreme_values();
        send_knot(0, Q_MIN);
        send_knot(kss_pkg::MAX_KNOTS - 1, Q_MAX);
        wait_for_spans();
        set_config(31, 511, 65535);
        send_query(Q_MAX);
        send_query(clamp_q(longint'(Q_MAX) - 65535));
        send_query(clamp_q(longint'(Q_MAX) - 65536));
        send_query(Q_MIN);
        wait_for_spans();
        set_config(1, 256, 0);
        send_query(Q_MIN);
    endtask

    // Random phases: idle the block, pick a setting (mostly short valid vectors,
    // some degenerate, a few full-length), maybe reload a sorted vector, then
    // mostly queries near stored knots with some random parameters and stray writes.
    task automatic test_random_traffic();
        int order;
        int count;
        int tol;
        int n_sat;
        int n_used;
        int phase_len;
        while (rand_items < RANDOM_ITEMS) begin
            wait_for_spans();
            case ($urandom_range(0, 9))
                6: begin
                    order = $urandom_range(1, 16);
                    count = $urandom_range(0, order);
                end
                7: begin
                    order = $urandom_range(1, 4);
                    count = $urandom_range(257, 511);
                end
                8: begin
                    order = $urandom_range(0, 31);
                    count = $urandom_range(0, 511);
                end
                9: begin
                    order = $urandom_range(1, 16);
                    count = $urandom_range(240, 256);
                end
                default: begin
                    order = $urandom_range(1, 6);
                    count = $urandom_range(order, order + 30);
                end
            endcase
            case ($urandom_range(0, 4))
                0: tol = 0;
                1: tol = 1;
                2: tol = $urandom_range(0, 255);
                3: tol = 65535;
                default: tol = $urandom_range(0, 65535);
            endcase
            set_config(order, count, tol);
            n_sat  = (cfg_count > kss_pkg::MAX_KNOTS) ? kss_pkg::MAX_KNOTS : cfg_count;
            n_used = (n_sat == 0) ? kss_pkg::MAX_KNOTS : n_sat;
            if (n_used <= 64 && $urandom_range(0, 1) == 1) begin
                load_knot_vector(n_used);
                rand_items += n_used;
            end
            phase_len = $urandom_range(30, 70);
            for (int k = 0; k < phase_len; k++) begin
                case ($urandom_range(0, 19))
                    0, 1: send_query(32'($urandom));
                    2, 3, 4: send_knot($urandom_range(0, kss_pkg::MAX_KNOTS - 1),
                                       32'($urandom));
                    default: send_query(param_near_knot(n_used));
                endcase
            end
            rand_items += phase_len;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        fill_knot_store();
        test_reset_config();
        test_degenerate_config();
        test_extreme_values();
        test_random_traffic();

        // Drain and let any stray result show up
        wait_for_spans();
        repeat (32) @(posedge i_clk);
        if (pending_spans.size() != 0) begin
            report_mismatch($sformatf("%0d span results never arrived", pending_spans.size()));
        end
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
